// ===== rtl/core/rcmp_pkg.sv =====
`default_nettype none
package rcmp_pkg;

	localparam int MAX_PIECES = 64;
	localparam int PRICE_BITS = 16;
	localparam int PROFIT_W   = 22;
	localparam int LEN_W      = 7;
	localparam int ROW        = MAX_PIECES + 1;
	localparam int IDX_W      = $clog2(ROW);
	localparam int TBL_DEPTH  = ROW * ROW;
	localparam int TBL_AW     = $clog2(TBL_DEPTH);
	localparam int PRICE_AW   = $clog2(MAX_PIECES);

	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [PROFIT_W-1:0]   profit_t;
	typedef logic [PRICE_BITS-1:0] price_t;
	typedef logic [TBL_AW-1:0]     tbl_addr_t;

	function automatic tbl_addr_t tbl_addr(input idx_t i, input idx_t j);
		return TBL_AW'(i) * TBL_AW'(ROW) + TBL_AW'(j);
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/rcmp_ram.sv =====
`default_nettype none
module rcmp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire                        clk,
	input  wire                        we,
	input  wire  [$clog2(DEPTH)-1:0]   wr_addr,
	input  wire  [WIDTH-1:0]           wr_data,
	input  wire  [$clog2(DEPTH)-1:0]   rd_addr,
	output logic [WIDTH-1:0]           rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule
`default_nettype wire

// ===== rtl/core/rod_cutting_max_profit.sv =====
`default_nettype none
// Rod cutting, maximal profit. Prices for piece lengths 1, 2, ... n arrive one request per
// cycle on start while busy is low; the request with last set closes the job (prices past
// 64 are dropped). The block then fills the profit table one cell per cycle, bounded by
// the single write port of each of the two table copies, and traces the cuts back in
// steps of a read state and a compare state (at most 2n steps), then a flush state closes
// the job. Results leave one per strobe on valid, longest cut first, with the
// profit on every result and final_res on the last; a job with no cut gives one result of
// length 0. The receiver cannot stall: take each result in the cycle valid is high.
module rod_cutting_max_profit
	import rcmp_pkg::*;
(
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	output logic                  busy,
	input  wire  [PRICE_BITS-1:0] price,
	input  wire                   last,
	output logic                  valid,
	output logic [PROFIT_W-1:0]   profit,
	output logic [LEN_W-1:0]      piece_length,
	output logic                  final_res
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_FILL   = 3'd1;
	localparam logic [2:0] ST_DRAIN  = 3'd2;
	localparam logic [2:0] ST_TB_RD  = 3'd3;
	localparam logic [2:0] ST_TB_CMP = 3'd4;
	localparam logic [2:0] ST_FLUSH  = 3'd5;

	logic [2:0] state_q;
	idx_t       cnt_q;
	idx_t       n_q;
	idx_t       row_q;
	idx_t       col_q;
	logic       first_q;
	logic       pend_v_q;
	idx_t       pend_len_q;
	profit_t    profit_q;
	logic       valid_q;
	idx_t       len_q;
	logic       fin_q;

	logic       v_s1;
	idx_t       row_s1;
	idx_t       col_s1;
	tbl_addr_t  wa_s1;
	profit_t    fwd_q;

	logic       accept;
	logic       keep_price;
	idx_t       cnt_next;
	price_t     pr_rd;
	profit_t    up_rd;
	profit_t    left_rd;
	tbl_addr_t  up_addr;
	tbl_addr_t  left_addr;
	idx_t       left_col;
	profit_t    up_v;
	profit_t    left_v;
	profit_t    take;
	profit_t    best_d;
	profit_t    tb_up;
	logic       tb_emit;
	idx_t       tb_i_next;
	idx_t       tb_j_next;

	assign busy       = (state_q != ST_IDLE);
	assign accept     = start && !busy;
	assign keep_price = (cnt_q < IDX_W'(MAX_PIECES));
	assign cnt_next   = keep_price ? cnt_q + IDX_W'(1) : cnt_q;

	assign left_col  = (state_q == ST_FILL) ? col_q - row_q : col_q;
	assign up_addr   = tbl_addr(row_q - IDX_W'(1), col_q);
	assign left_addr = tbl_addr(row_q, left_col);

	rcmp_ram #(.WIDTH(PRICE_BITS), .DEPTH(MAX_PIECES)) u_price_ram (
		.clk     (clk),
		.we      (accept && keep_price),
		.wr_addr (cnt_q[PRICE_AW-1:0]),
		.wr_data (price),
		.rd_addr (PRICE_AW'(row_q - IDX_W'(1))),
		.rd_data (pr_rd)
	);

	rcmp_ram #(.WIDTH(PROFIT_W), .DEPTH(TBL_DEPTH)) u_tbl_up (
		.clk     (clk),
		.we      (v_s1),
		.wr_addr (wa_s1),
		.wr_data (best_d),
		.rd_addr (up_addr),
		.rd_data (up_rd)
	);

	rcmp_ram #(.WIDTH(PROFIT_W), .DEPTH(TBL_DEPTH)) u_tbl_left (
		.clk     (clk),
		.we      (v_s1),
		.wr_addr (wa_s1),
		.wr_data (best_d),
		.rd_addr (left_addr),
		.rd_data (left_rd)
	);

	always_comb begin
		up_v = (row_s1 == IDX_W'(1)) ? '0 : up_rd;
		if (col_s1 == row_s1) begin
			left_v = '0;
		end else if (row_s1 == IDX_W'(1)) begin
			left_v = fwd_q;
		end else begin
			left_v = left_rd;
		end
		take   = PROFIT_W'(pr_rd) + left_v;
		best_d = ((row_s1 <= col_s1) && (take > up_v)) ? take : up_v;
	end

	always_comb begin
		tb_up     = (row_q == IDX_W'(1)) ? '0 : up_rd;
		tb_emit   = (left_rd != tb_up);
		tb_i_next = tb_emit ? row_q : row_q - IDX_W'(1);
		tb_j_next = tb_emit ? col_q - row_q : col_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_FILL);
		end
	end

	always_ff @(posedge clk) begin
		row_s1 <= row_q;
		col_s1 <= col_q;
		wa_s1  <= tbl_addr(row_q, col_q);
		if (v_s1) begin
			fwd_q <= best_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			first_q  <= 1'b0;
			pend_v_q <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q <= cnt_next;
						if (last) begin
							state_q <= ST_FILL;
						end
					end
				end
				ST_FILL: begin
					if (col_q == n_q && row_q == n_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					first_q  <= 1'b1;
					pend_v_q <= 1'b0;
					state_q  <= ST_TB_RD;
				end
				ST_TB_RD: begin
					state_q <= ST_TB_CMP;
				end
				ST_TB_CMP: begin
					first_q <= 1'b0;
					if (tb_emit) begin
						pend_v_q <= 1'b1;
						if (pend_v_q) begin
							valid_q <= 1'b1;
						end
					end
					if (tb_i_next == '0 || tb_j_next == '0) begin
						state_q <= ST_FLUSH;
					end else begin
						state_q <= ST_TB_RD;
					end
				end
				ST_FLUSH: begin
					valid_q <= 1'b1;
					cnt_q   <= '0;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				row_q <= IDX_W'(1);
				col_q <= IDX_W'(1);
				if (accept && last) begin
					n_q <= cnt_next;
				end
			end
			ST_FILL: begin
				if (col_q == n_q) begin
					col_q <= IDX_W'(1);
					row_q <= row_q + IDX_W'(1);
				end else begin
					col_q <= col_q + IDX_W'(1);
				end
			end
			ST_DRAIN: begin
				row_q <= n_q;
				col_q <= n_q;
			end
			ST_TB_CMP: begin
				if (first_q) begin
					profit_q <= left_rd;
				end
				row_q <= tb_i_next;
				col_q <= tb_j_next;
				if (tb_emit) begin
					pend_len_q <= row_q;
					len_q      <= pend_len_q;
					fin_q      <= 1'b0;
				end
			end
			ST_FLUSH: begin
				len_q <= pend_v_q ? pend_len_q : '0;
				fin_q <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign valid        = valid_q;
	assign profit       = profit_q;
	assign piece_length = LEN_W'(len_q);
	assign final_res    = fin_q;

`ifndef NO_ASSERTIONS
	a_fill_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FILL |-> row_q >= IDX_W'(1) && row_q <= n_q &&
			col_q >= IDX_W'(1) && col_q <= n_q)
		else $error("fill index outside the table");

	a_more_follows: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !final_res |-> busy)
		else $error("non-final result after job end");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= IDX_W'(MAX_PIECES))
		else $error("price count past capacity");

	a_flush_ends_job: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FLUSH |=> valid && final_res && !busy)
		else $error("job closed without final result");
`endif

endmodule
`default_nettype wire
